/* design/assert_macros.svh */
// Assertion macros shared by the execute unit RTL.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RVX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RVX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rvx_pkg.sv */
// Types, operation codes and pipeline depths for the RV32IM execute unit.
// Depends on nothing.
package rvx_pkg;

  localparam int XLEN      = 32;
  localparam int MUL_LAT   = 2;
  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  localparam logic [4:0] OP_ADD    = 5'd0;
  localparam logic [4:0] OP_SUB    = 5'd1;
  localparam logic [4:0] OP_SLL    = 5'd2;
  localparam logic [4:0] OP_SLT    = 5'd3;
  localparam logic [4:0] OP_SLTU   = 5'd4;
  localparam logic [4:0] OP_XOR    = 5'd5;
  localparam logic [4:0] OP_SRL    = 5'd6;
  localparam logic [4:0] OP_SRA    = 5'd7;
  localparam logic [4:0] OP_OR     = 5'd8;
  localparam logic [4:0] OP_AND    = 5'd9;
  localparam logic [4:0] OP_MUL    = 5'd10;
  localparam logic [4:0] OP_MULH   = 5'd11;
  localparam logic [4:0] OP_MULHSU = 5'd12;
  localparam logic [4:0] OP_MULHU  = 5'd13;
  localparam logic [4:0] OP_DIV    = 5'd14;
  localparam logic [4:0] OP_DIVU   = 5'd15;
  localparam logic [4:0] OP_REM    = 5'd16;
  localparam logic [4:0] OP_REMU   = 5'd17;
  localparam logic [4:0] OP_BEQ    = 5'd18;
  localparam logic [4:0] OP_BNE    = 5'd19;
  localparam logic [4:0] OP_BLT    = 5'd20;
  localparam logic [4:0] OP_BGE    = 5'd21;
  localparam logic [4:0] OP_BLTU   = 5'd22;
  localparam logic [4:0] OP_BGEU   = 5'd23;
  localparam logic [4:0] OP_JAL    = 5'd24;
  localparam logic [4:0] OP_JALR   = 5'd25;
  localparam logic [4:0] OP_LUI    = 5'd26;
  localparam logic [4:0] OP_AUIPC  = 5'd27;
  localparam logic [4:0] OP_CSRRW  = 5'd28;
  localparam logic [4:0] OP_CSRRS  = 5'd29;
  localparam logic [4:0] OP_CSRRC  = 5'd30;

  typedef struct packed {
    logic [4:0]      operation;
    logic            use_immediate;
    logic [XLEN-1:0] rs1_value;
    logic [XLEN-1:0] rs2_value;
    logic [XLEN-1:0] immediate;
    logic [XLEN-1:0] pc_value;
    logic [XLEN-1:0] csr_old;
  } exe_in_t;

  typedef struct packed {
    logic [XLEN-1:0] rd_result;
    logic [XLEN-1:0] csr_new;
    logic            redirect;
    logic [XLEN-1:0] target_pc;
  } exe_out_t;

  typedef struct packed {
    exe_out_t res;
    logic     is_mul;
    logic     is_div;
  } exe_rec_t;

endpackage

/* design/rvx_mul.sv */
// Two-stage 32x32 multiplier built from four 17x17 partial products.
// Depends on rvx_pkg.
module rvx_mul import rvx_pkg::*; (
  input  logic            clk,
  input  logic            adv,
  input  logic [4:0]      op,
  input  logic [XLEN-1:0] a,
  input  logic [XLEN-1:0] b,
  output logic [XLEN-1:0] result
);

  logic               a_sgn, b_sgn;
  logic signed [16:0] ah, al, bh, bl;
  logic signed [33:0] pll_r, plh_r, phl_r, phh_r;
  logic               hi_r;
  logic signed [63:0] sum;
  logic [XLEN-1:0]    res_r;

  always_comb begin
    a_sgn = (op == OP_MULH) || (op == OP_MULHSU);
    b_sgn = (op == OP_MULH);
    ah    = {a_sgn & a[31], a[31:16]};
    al    = {1'b0, a[15:0]};
    bh    = {b_sgn & b[31], b[31:16]};
    bl    = {1'b0, b[15:0]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pll_r <= al * bl;
      plh_r <= al * bh;
      phl_r <= ah * bl;
      phh_r <= ah * bh;
      hi_r  <= (op != OP_MUL);
    end
  end

  always_comb begin
    sum = 64'(pll_r) + (64'(plh_r) <<< 16) + (64'(phl_r) <<< 16) + (64'(phh_r) <<< 32);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= hi_r ? sum[63:32] : sum[31:0];
    end
  end

  assign result = res_r;

endmodule

/* design/rvx_div.sv */
// Fully pipelined restoring divider: sign prep, one quotient bit per stage, sign fix.
// Depends on rvx_pkg.
module rvx_div import rvx_pkg::*; (
  input  logic            clk,
  input  logic            adv,
  input  logic [4:0]      op,
  input  logic [XLEN-1:0] a,
  input  logic [XLEN-1:0] b,
  output logic [XLEN-1:0] result
);

  typedef struct packed {
    logic want_rem;
    logic neg_q;
    logic neg_r;
    logic dzero;
  } div_flg_t;

  logic [XLEN-1:0] rem_r [0:DIV_STEPS];
  logic [XLEN-1:0] quo_r [0:DIV_STEPS];
  logic [XLEN-1:0] dvs_r [0:DIV_STEPS];
  div_flg_t        flg_r [0:DIV_STEPS];
  logic [XLEN-1:0] rem_nxt [1:DIV_STEPS];
  logic [XLEN-1:0] quo_nxt [1:DIV_STEPS];
  logic            sgn, a_neg, b_neg;
  logic [XLEN-1:0] qfix, rfix, res_r;

  always_comb begin
    sgn   = (op == OP_DIV) || (op == OP_REM);
    a_neg = sgn & a[XLEN-1];
    b_neg = sgn & b[XLEN-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]          <= '0;
      quo_r[0]          <= a_neg ? -a : a;
      dvs_r[0]          <= b_neg ? -b : b;
      flg_r[0].want_rem <= (op == OP_REM) || (op == OP_REMU);
      flg_r[0].neg_q    <= a_neg ^ b_neg;
      flg_r[0].neg_r    <= a_neg;
      flg_r[0].dzero    <= (b == '0);
    end
  end

  always_comb begin
    logic [XLEN:0] t, d;
    for (int i = 1; i <= DIV_STEPS; i++) begin
      t = {rem_r[i-1], quo_r[i-1][XLEN-1]};
      d = t - {1'b0, dvs_r[i-1]};
      rem_nxt[i] = d[XLEN] ? t[XLEN-1:0] : d[XLEN-1:0];
      quo_nxt[i] = {quo_r[i-1][XLEN-2:0], ~d[XLEN]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 1; i <= DIV_STEPS; i++) begin
        rem_r[i] <= rem_nxt[i];
        quo_r[i] <= quo_nxt[i];
        dvs_r[i] <= dvs_r[i-1];
        flg_r[i] <= flg_r[i-1];
      end
    end
  end

  always_comb begin
    qfix = flg_r[DIV_STEPS].neg_q ? -quo_r[DIV_STEPS] : quo_r[DIV_STEPS];
    if (flg_r[DIV_STEPS].dzero) begin
      qfix = '1;
    end
    rfix = flg_r[DIV_STEPS].neg_r ? -rem_r[DIV_STEPS] : rem_r[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= flg_r[DIV_STEPS].want_rem ? rfix : qfix;
    end
  end

  assign result = res_r;

endmodule

/* design/rv32im_execute_unit.sv */
// Top level of the RV32IM execute unit: input stage, ALU, delay line, output stage.
// Depends on rvx_pkg, rvx_mul, rvx_div and assert_macros.svh.
//
// Input channel in_valid/in_ready/in_data carries one instruction per beat:
// operation, operand B select, rs1, rs2, immediate, PC and the old CSR value.
// Output channel out_valid/out_ready/out_data carries one result per beat:
// rd value, new CSR value, redirect flag and target PC, in input order.
// Every instruction takes the same path length: input register, 34 stages
// (set by the divider: sign prep, 32 one-bit quotient stages, sign fix),
// and the output register, which drives out_valid. One instruction per cycle
// is taken while the receiver does not stall. ALU, branch, jump and CSR results
// are formed in the first stage and ride a delay line; multiply results join
// it after two stages and divide results at its end.
// When the receiver stalls with a result pending, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated. in_ready stays high while
// the output register is empty or being taken.
// Reset (rst_n low, synchronous) clears every valid bit; data registers are
// not reset.
`include "assert_macros.svh"

module rv32im_execute_unit import rvx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  exe_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output exe_out_t out_data
);

  logic             adv;
  logic             s0_vld_r;
  exe_in_t          s0_r;
  exe_rec_t         alu_rec;
  exe_rec_t         line_r [1:DIV_LAT];
  exe_rec_t         line_nxt [1:DIV_LAT];
  logic [DIV_LAT:1] vld_r;
  logic [XLEN-1:0]  mul_res, div_res;
  logic             out_vld_r;
  exe_out_t         out_r;
  exe_out_t         out_nxt;

  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r <= in_data;
    end
  end

  always_comb begin
    logic [XLEN-1:0] a, b, imm, pc;
    logic [4:0]      sh;
    logic            lts, ltu, eq;
    a   = s0_r.rs1_value;
    imm = s0_r.immediate;
    pc  = s0_r.pc_value;
    b   = (s0_r.use_immediate && s0_r.operation <= OP_AND) ? imm : s0_r.rs2_value;
    sh  = b[4:0];
    lts = $signed(a) < $signed(b);
    ltu = a < b;
    eq  = (a == b);
    alu_rec = '0;
    alu_rec.is_mul = (s0_r.operation >= OP_MUL) && (s0_r.operation <= OP_MULHU);
    alu_rec.is_div = (s0_r.operation >= OP_DIV) && (s0_r.operation <= OP_REMU);
    unique case (s0_r.operation)
      OP_ADD:  alu_rec.res.rd_result = a + b;
      OP_SUB:  alu_rec.res.rd_result = a - b;
      OP_SLL:  alu_rec.res.rd_result = a << sh;
      OP_SLT:  alu_rec.res.rd_result = {{(XLEN-1){1'b0}}, lts};
      OP_SLTU: alu_rec.res.rd_result = {{(XLEN-1){1'b0}}, ltu};
      OP_XOR:  alu_rec.res.rd_result = a ^ b;
      OP_SRL:  alu_rec.res.rd_result = a >> sh;
      OP_SRA:  alu_rec.res.rd_result = XLEN'($signed(a) >>> sh);
      OP_OR:   alu_rec.res.rd_result = a | b;
      OP_AND:  alu_rec.res.rd_result = a & b;
      OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU,
      OP_DIV, OP_DIVU, OP_REM, OP_REMU: alu_rec.res.rd_result = '0;
      OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
        unique case (s0_r.operation)
          OP_BEQ:  alu_rec.res.redirect = eq;
          OP_BNE:  alu_rec.res.redirect = !eq;
          OP_BLT:  alu_rec.res.redirect = lts;
          OP_BGE:  alu_rec.res.redirect = !lts;
          OP_BLTU: alu_rec.res.redirect = ltu;
          default: alu_rec.res.redirect = !ltu;
        endcase
        alu_rec.res.target_pc = alu_rec.res.redirect ? pc + imm : '0;
      end
      OP_JAL: begin
        alu_rec.res.rd_result = pc + XLEN'(4);
        alu_rec.res.redirect  = 1'b1;
        alu_rec.res.target_pc = pc + imm;
      end
      OP_JALR: begin
        alu_rec.res.rd_result = pc + XLEN'(4);
        alu_rec.res.redirect  = 1'b1;
        alu_rec.res.target_pc = (a + imm) & ~XLEN'(1);
      end
      OP_LUI:   alu_rec.res.rd_result = imm << 12;
      OP_AUIPC: alu_rec.res.rd_result = pc + (imm << 12);
      OP_CSRRW: begin
        alu_rec.res.rd_result = s0_r.csr_old;
        alu_rec.res.csr_new   = a;
      end
      OP_CSRRS: begin
        alu_rec.res.rd_result = s0_r.csr_old;
        alu_rec.res.csr_new   = s0_r.csr_old | a;
      end
      OP_CSRRC: begin
        alu_rec.res.rd_result = s0_r.csr_old;
        alu_rec.res.csr_new   = s0_r.csr_old & ~a;
      end
      default: alu_rec = '0;
    endcase
  end

  rvx_mul u_mul (
    .clk    (clk),
    .adv    (adv),
    .op     (s0_r.operation),
    .a      (s0_r.rs1_value),
    .b      (s0_r.rs2_value),
    .result (mul_res)
  );

  rvx_div u_div (
    .clk    (clk),
    .adv    (adv),
    .op     (s0_r.operation),
    .a      (s0_r.rs1_value),
    .b      (s0_r.rs2_value),
    .result (div_res)
  );

  always_comb begin
    line_nxt[1] = alu_rec;
    for (int k = 2; k <= DIV_LAT; k++) begin
      line_nxt[k] = line_r[k-1];
      if (k == MUL_LAT + 1 && line_r[k-1].is_mul) begin
        line_nxt[k].res.rd_result = mul_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DIV_LAT-1:1], s0_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= DIV_LAT; k++) begin
        line_r[k] <= line_nxt[k];
      end
    end
  end

  always_comb begin
    out_nxt = line_r[DIV_LAT].res;
    if (line_r[DIV_LAT].is_div) begin
      out_nxt.rd_result = div_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_r[DIV_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `RVX_ASSERT_NEXT(a_hold_line, out_vld_r && !out_ready, $stable(vld_r) && $stable(s0_vld_r), "pipeline moved during stall")
  `RVX_ASSERT_NOW(a_target_zero, out_vld_r && !out_r.redirect, out_r.target_pc == '0, "target set without redirect")
  `RVX_ASSERT_NOW(a_csr_no_jump, out_vld_r && out_r.csr_new != '0, !out_r.redirect, "csr result with redirect")

endmodule
